FILE: rtl/core/rc4_pkg.sv
// Shared types and constants for the RC4 stream cipher engine.
// Holds the command format passed from the front end to the cipher core.
// No dependencies.
package rc4_pkg;

    // Byte and permutation geometry
    localparam int BYTE_W     = 8;
    localparam int PERM_DEPTH = 256;
    localparam int PERM_IDX_W = 8;

    // Key store geometry at its largest; the top parameter limits the depth
    localparam int MAX_KEY_BYTES_DEF = 256;
    localparam int KEY_ADDR_W        = 8;
    localparam int KEY_CNT_W         = 9;

    // Command queue between front end and core
    localparam int CMDQ_DEPTH = 2;
    localparam int CMDQ_LVL_W = 2;

    // Item kinds on the request channel
    localparam logic KIND_KEY  = 1'b0;
    localparam logic KIND_DATA = 1'b1;

    // Core operations
    typedef logic [1:0] op_t;
    localparam op_t OP_DATA    = 2'd0;
    localparam op_t OP_KEY     = 2'd1;
    localparam op_t OP_KEY_RUN = 2'd2;
    localparam op_t OP_RUN     = 2'd3;

    typedef struct packed {
        op_t                   op;
        logic [BYTE_W-1:0]     byte_val;
        logic                  last;
        logic [KEY_ADDR_W-1:0] kaddr;
        logic [KEY_CNT_W-1:0]  klen;
    } cmd_t;

    // Core status seen by the top level
    typedef struct packed {
        logic sched;
        logic out_load;
    } bk_stat_t;

endpackage

FILE: rtl/core/rc4_req_if.sv
// Request channel of the RC4 engine: key and data items.
// Depends on nothing.
interface rc4_req_if;
    logic       valid;
    logic       ready;
    logic       kind;
    logic [7:0] byte_in;
    logic       last;

    modport source (output valid, output kind, output byte_in, output last, input ready);
    modport sink   (input valid, input kind, input byte_in, input last, output ready);
endinterface

FILE: rtl/core/rc4_rsp_if.sv
// Response channel of the RC4 engine: one item per data byte.
// Depends on nothing.
interface rc4_rsp_if;
    logic       valid;
    logic       ready;
    logic [7:0] byte_out;
    logic       last_out;

    modport source (output valid, output byte_out, output last_out, input ready);
    modport sink   (input valid, input byte_out, input last_out, output ready);
endinterface

FILE: rtl/core/rc4_front.sv
// Front end: accepts request items, tracks key length, emits core commands.
// Depends on rc4_pkg and rc4_req_if.
module rc4_front #(
    parameter int MAX_KEY_BYTES = rc4_pkg::MAX_KEY_BYTES_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    rc4_req_if.sink       req,
    output rc4_pkg::cmd_t cmd,
    output logic          cmd_valid,
    input  logic          cmd_ready
);
    import rc4_pkg::*;

    logic [KEY_CNT_W-1:0] count_reg, count_next;
    logic [KEY_CNT_W-1:0] cnt_inc;
    logic                 room;
    logic                 accept;

    assign req.ready = cmd_ready;
    assign accept    = req.valid & cmd_ready;
    assign room      = count_reg < KEY_CNT_W'(MAX_KEY_BYTES);
    assign cnt_inc   = count_reg + KEY_CNT_W'(1);

    // Classify; over-limit key bytes are dropped, a last one becomes OP_RUN
    always_comb
    begin
        cmd.byte_val = req.byte_in;
        cmd.last     = req.last;
        cmd.kaddr    = count_reg[KEY_ADDR_W-1:0];
        cmd.klen     = room ? cnt_inc : count_reg;
        cmd.op       = OP_DATA;
        cmd_valid    = 1'b0;
        count_next   = count_reg;
        if (req.valid)
        begin
            if (req.kind == KIND_DATA)
            begin
                cmd.op    = OP_DATA;
                cmd_valid = 1'b1;
            end
            else
            begin
                if (room)
                    cmd.op = req.last ? OP_KEY_RUN : OP_KEY;
                else
                    cmd.op = OP_RUN;
                cmd_valid = room | req.last;
                if (accept)
                begin
                    if (req.last)
                        count_next = '0;
                    else if (room)
                        count_next = cnt_inc;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= '0;
        else
            count_reg <= count_next;
    end

endmodule

FILE: rtl/core/rc4_cmd_fifo.sv
// Two-entry command queue between the front end and the cipher core.
// Depends on rc4_pkg.
module rc4_cmd_fifo (
    input  logic                           clk,
    input  logic                           rst_n,
    input  rc4_pkg::cmd_t                  push_cmd,
    input  logic                           push_valid,
    output logic                           push_ready,
    output rc4_pkg::cmd_t                  pop_cmd,
    output logic                           pop_valid,
    input  logic                           pop,
    output logic [rc4_pkg::CMDQ_LVL_W-1:0] level
);
    import rc4_pkg::*;

    cmd_t                  entry_reg [CMDQ_DEPTH];
    logic                  wptr_reg, rptr_reg;
    logic [CMDQ_LVL_W-1:0] level_reg;
    logic                  do_push, do_pop;

    assign push_ready = level_reg != CMDQ_LVL_W'(CMDQ_DEPTH);
    assign pop_valid  = level_reg != '0;
    assign pop_cmd    = entry_reg[rptr_reg];
    assign level      = level_reg;
    assign do_push    = push_valid & push_ready;
    assign do_pop     = pop & pop_valid;

    // Storage
    always_ff @(posedge clk)
    begin
        if (do_push)
            entry_reg[wptr_reg] <= push_cmd;
    end

    // Pointers and fill level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= 1'b0;
            rptr_reg  <= 1'b0;
            level_reg <= '0;
        end
        else
        begin
            if (do_push)
                wptr_reg <= ~wptr_reg;
            if (do_pop)
                rptr_reg <= ~rptr_reg;
            if (do_push && !do_pop)
                level_reg <= level_reg + CMDQ_LVL_W'(1);
            else if (do_pop && !do_push)
                level_reg <= level_reg - CMDQ_LVL_W'(1);
        end
    end

endmodule

FILE: rtl/core/rc4_core.sv
// Cipher core: permutation memory, key store, key schedule and keystream.
// Depends on rc4_pkg and rc4_rsp_if.
module rc4_core #(
    parameter int MAX_KEY_BYTES = rc4_pkg::MAX_KEY_BYTES_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  rc4_pkg::cmd_t     cmd,
    input  logic              cmd_valid,
    output logic              cmd_pop,
    rc4_rsp_if.source         rsp,
    output rc4_pkg::bk_stat_t stat
);
    import rc4_pkg::*;

    localparam int KIDX_W = (MAX_KEY_BYTES > 1) ? $clog2(MAX_KEY_BYTES) : 1;

    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_D1   = 4'd1;
    localparam logic [3:0] ST_D2   = 4'd2;
    localparam logic [3:0] ST_D3   = 4'd3;
    localparam logic [3:0] ST_SCLR = 4'd4;
    localparam logic [3:0] ST_S0   = 4'd5;
    localparam logic [3:0] ST_S1   = 4'd6;
    localparam logic [3:0] ST_S2   = 4'd7;
    localparam logic [3:0] ST_S3   = 4'd8;

    logic [3:0]            state_reg, state_next;
    logic [PERM_IDX_W-1:0] x_reg, x_next, y_reg, y_next;
    logic [PERM_IDX_W-1:0] i_reg, i_next, j_reg, j_next;
    logic [KEY_ADDR_W-1:0] k_reg, k_next;
    logic [KEY_CNT_W-1:0]  len_reg, len_next;
    logic [BYTE_W-1:0]     a_reg, a_next, b_reg, b_next;
    logic [BYTE_W-1:0]     din_reg, din_next;
    logic                  dlast_reg, dlast_next;
    logic [BYTE_W-1:0]     obyte_reg, obyte_next;
    logic                  olast_reg, olast_next;
    logic                  ovalid_reg, ovalid_next;

    // Permutation memory with per-entry valid bits; invalid reads as identity
    logic [BYTE_W-1:0]     perm_mem [PERM_DEPTH];
    logic [PERM_DEPTH-1:0] perm_vld_reg;
    logic [BYTE_W-1:0]     perm_rd_reg;
    logic                  perm_rvld_reg;
    logic [PERM_IDX_W-1:0] perm_raddr_reg;
    logic                  perm_re, perm_we, perm_clr;
    logic [PERM_IDX_W-1:0] perm_raddr, perm_waddr;
    logic [BYTE_W-1:0]     perm_wdata, perm_rdata;

    // Key store
    logic [BYTE_W-1:0]     key_mem [MAX_KEY_BYTES];
    logic [BYTE_W-1:0]     key_rd_reg;
    logic                  key_we, key_re;

    logic [PERM_IDX_W-1:0] t_sum;
    logic [BYTE_W-1:0]     ks;
    logic                  out_free;
    logic [KEY_CNT_W-1:0]  k_inc;
    logic                  out_load;
    logic                  sched_st;

    assign perm_rdata = perm_rvld_reg ? perm_rd_reg : perm_raddr_reg;
    assign t_sum      = a_reg + b_reg;
    assign out_free   = !ovalid_reg || rsp.ready;
    assign k_inc      = KEY_CNT_W'(k_reg) + KEY_CNT_W'(1);

    // Keystream byte after the swap: forward the two entries just rewritten
    always_comb
    begin
        if (t_sum == y_reg)
            ks = a_reg;
        else if (t_sum == x_reg)
            ks = b_reg;
        else
            ks = perm_rdata;
    end

    // Sequencer
    always_comb
    begin
        state_next  = state_reg;
        x_next      = x_reg;
        y_next      = y_reg;
        i_next      = i_reg;
        j_next      = j_reg;
        k_next      = k_reg;
        len_next    = len_reg;
        a_next      = a_reg;
        b_next      = b_reg;
        din_next    = din_reg;
        dlast_next  = dlast_reg;
        obyte_next  = obyte_reg;
        olast_next  = olast_reg;
        ovalid_next = ovalid_reg && !rsp.ready;
        cmd_pop     = 1'b0;
        perm_re     = 1'b0;
        perm_raddr  = x_reg;
        perm_we     = 1'b0;
        perm_waddr  = x_reg;
        perm_wdata  = b_reg;
        perm_clr    = 1'b0;
        key_we      = 1'b0;
        key_re      = 1'b0;
        out_load    = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    cmd_pop  = 1'b1;
                    len_next = cmd.klen;
                    case (cmd.op)
                        OP_DATA:
                        begin
                            x_next     = x_reg + PERM_IDX_W'(1);
                            perm_re    = 1'b1;
                            perm_raddr = x_reg + PERM_IDX_W'(1);
                            din_next   = cmd.byte_val;
                            dlast_next = cmd.last;
                            state_next = ST_D1;
                        end
                        OP_KEY:
                            key_we = 1'b1;
                        OP_KEY_RUN:
                        begin
                            key_we     = 1'b1;
                            state_next = ST_SCLR;
                        end
                        default:
                            state_next = ST_SCLR;
                    endcase
                end
            end
            ST_D1:
            begin
                a_next     = perm_rdata;
                y_next     = y_reg + perm_rdata;
                perm_re    = 1'b1;
                perm_raddr = y_reg + perm_rdata;
                state_next = ST_D2;
            end
            ST_D2:
            begin
                b_next     = perm_rdata;
                perm_we    = 1'b1;
                perm_waddr = x_reg;
                perm_wdata = perm_rdata;
                perm_re    = 1'b1;
                perm_raddr = a_reg + perm_rdata;
                state_next = ST_D3;
            end
            ST_D3:
            begin
                if (out_free)
                begin
                    perm_we     = 1'b1;
                    perm_waddr  = y_reg;
                    perm_wdata  = a_reg;
                    obyte_next  = din_reg ^ ks;
                    olast_next  = dlast_reg;
                    ovalid_next = 1'b1;
                    out_load    = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            ST_SCLR:
            begin
                perm_clr   = 1'b1;
                i_next     = '0;
                j_next     = '0;
                k_next     = '0;
                x_next     = '0;
                y_next     = '0;
                state_next = ST_S0;
            end
            ST_S0:
            begin
                perm_re    = 1'b1;
                perm_raddr = i_reg;
                key_re     = 1'b1;
                state_next = ST_S1;
            end
            ST_S1:
            begin
                a_next     = perm_rdata;
                j_next     = j_reg + key_rd_reg + perm_rdata;
                perm_re    = 1'b1;
                perm_raddr = j_reg + key_rd_reg + perm_rdata;
                state_next = ST_S2;
            end
            ST_S2:
            begin
                perm_we    = 1'b1;
                perm_waddr = i_reg;
                perm_wdata = perm_rdata;
                state_next = ST_S3;
            end
            ST_S3:
            begin
                perm_we    = 1'b1;
                perm_waddr = j_reg;
                perm_wdata = a_reg;
                i_next     = i_reg + PERM_IDX_W'(1);
                k_next     = (k_inc == len_reg) ? '0 : k_inc[KEY_ADDR_W-1:0];
                state_next = (i_reg == PERM_IDX_W'(PERM_DEPTH - 1)) ? ST_IDLE : ST_S0;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    assign sched_st = (state_reg == ST_SCLR) || (state_reg == ST_S0) ||
                      (state_reg == ST_S1) || (state_reg == ST_S2) ||
                      (state_reg == ST_S3);

    // Status toward the top level
    assign stat = '{sched: sched_st, out_load: out_load};

    // Permutation memory: one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (perm_we)
            perm_mem[perm_waddr] <= perm_wdata;
        if (perm_re)
        begin
            perm_rd_reg    <= perm_mem[perm_raddr];
            perm_rvld_reg  <= perm_vld_reg[perm_raddr];
            perm_raddr_reg <= perm_raddr;
        end
    end

    // Valid bits: cleared by reset and at the start of a key schedule
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            perm_vld_reg <= '0;
        else if (perm_clr)
            perm_vld_reg <= '0;
        else if (perm_we)
            perm_vld_reg[perm_waddr] <= 1'b1;
    end

    // Key store
    always_ff @(posedge clk)
    begin
        if (key_we)
            key_mem[cmd.kaddr[KIDX_W-1:0]] <= cmd.byte_val;
        if (key_re)
            key_rd_reg <= key_mem[k_reg[KIDX_W-1:0]];
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            x_reg      <= '0;
            y_reg      <= '0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            x_reg      <= x_next;
            y_reg      <= y_next;
            ovalid_reg <= ovalid_next;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        i_reg     <= i_next;
        j_reg     <= j_next;
        k_reg     <= k_next;
        len_reg   <= len_next;
        a_reg     <= a_next;
        b_reg     <= b_next;
        din_reg   <= din_next;
        dlast_reg <= dlast_next;
        obyte_reg <= obyte_next;
        olast_reg <= olast_next;
    end

    assign rsp.valid    = ovalid_reg;
    assign rsp.byte_out = obyte_reg;
    assign rsp.last_out = olast_reg;

endmodule

FILE: rtl/core/rc4_stream_cipher_top.sv
// RC4 engine top level: front end, command queue and cipher core.
// Depends on rc4_pkg, rc4_req_if, rc4_rsp_if, rc4_front, rc4_cmd_fifo, rc4_core.
//
// Key bytes (kind 0) are stored in order; the key byte marked last starts the
// key schedule. Data bytes (kind 1) each come back XORed with the next
// keystream byte, last copied to last_out; key items give no response. Items
// pass through a two-entry command queue. In the core a key byte is written to
// the key store from idle; a data byte passes states D1, D2 and D3 to the output
// register, waiting in D3 while it is still held; the key schedule clears the
// valid bits, then runs states S0 to S3 once per entry. All are paced by the
// single permutation memory, which does one read and one write per cycle and is
// walked through dependent read, read, write, write steps. Key bytes beyond
// MAX_KEY_BYTES are dropped. Before any key, data uses the identity permutation.
module rc4_stream_cipher_top #(
    parameter int MAX_KEY_BYTES = rc4_pkg::MAX_KEY_BYTES_DEF
) (
    input logic       clk,
    input logic       rst_n,
    rc4_req_if.sink   req,
    rc4_rsp_if.source rsp
);
    import rc4_pkg::*;

    cmd_t                  fe_cmd, q_cmd;
    logic                  fe_valid, fe_ready;
    logic                  q_valid, q_pop;
    logic [CMDQ_LVL_W-1:0] q_level;
    bk_stat_t              bk_stat;

    rc4_front #(
        .MAX_KEY_BYTES (MAX_KEY_BYTES)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .cmd       (fe_cmd),
        .cmd_valid (fe_valid),
        .cmd_ready (fe_ready)
    );

    rc4_cmd_fifo u_cmdq (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_cmd   (fe_cmd),
        .push_valid (fe_valid),
        .push_ready (fe_ready),
        .pop_cmd    (q_cmd),
        .pop_valid  (q_valid),
        .pop        (q_pop),
        .level      (q_level)
    );

    rc4_core #(
        .MAX_KEY_BYTES (MAX_KEY_BYTES)
    ) u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (q_cmd),
        .cmd_valid (q_valid),
        .cmd_pop   (q_pop),
        .rsp       (rsp),
        .stat      (bk_stat)
    );

    // Queue never holds more than its depth
    a_q_bound: assert property (@(posedge clk) disable iff (!rst_n)
        q_level <= CMDQ_LVL_W'(CMDQ_DEPTH))
        else $error("command queue overfilled");

    // A new response only follows a keystream computation
    a_rsp_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp.valid) |-> $past(bk_stat.out_load))
        else $error("response without data item");

    // No response is produced while the key schedule runs
    a_sched_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (bk_stat.sched && rsp.valid && rsp.ready) |=> !rsp.valid)
        else $error("response during key schedule");

endmodule
